// ===== rtl/tma_pkg.sv =====
// Shared constants, types and state codes of the trimmed moving-average filter.
`default_nettype none

package tma_pkg;

  localparam int SAMPLE_W       = 12;
  localparam int WINDOW_W       = 5;
  localparam int DATA_W         = 32;
  localparam int ADDR_W         = 2;
  localparam int RING_DEPTH_DEF = 16;
  localparam int TRIM_COUNT     = 2;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET    = WINDOW_W'(16);
  localparam logic [ADDR_W-1:0]   REG_WINDOW_ADDR = ADDR_W'(0);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_TRIM,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/trimmed_moving_average_filter.sv =====
// Top level of the trimmed moving-average filter: ring of cells, walk, trim and divide control.
//
//   Channel   Direction  Handshake                       Payload
//   sample    in         sample_valid / sample_stall     sample [11:0]
//   filtered  out        filtered_valid / filtered_stall filtered [11:0]
//   config    in         APB psel / penable / pready     window_length at address 0
//
// An item passes from its transfer through one ring shift per entry, one trim step, the
// divider and the load of its result into the output register; a zero window skips the
// divider. The next sample is taken once the result sits in the output register, even if
// that result is still stalled, so a new sample is never taken while one is in progress.
// Reset clears the ring and the write slot and sets the window to 16.
`default_nettype none

module trimmed_moving_average_filter #(
  parameter int RING_DEPTH = tma_pkg::RING_DEPTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [tma_pkg::ADDR_W-1:0]           paddr,
  input  wire  [tma_pkg::DATA_W-1:0]           pwdata,
  output logic [tma_pkg::DATA_W-1:0]           prdata,
  output logic                                 pready,
  input  wire  [tma_pkg::SAMPLE_W-1:0]         sample,
  input  wire                                  sample_valid,
  output logic                                 sample_stall,
  output logic [tma_pkg::SAMPLE_W-1:0]         filtered,
  output logic                                 filtered_valid,
  input  wire                                  filtered_stall
);

  localparam int SW  = tma_pkg::SAMPLE_W;
  localparam int WW  = tma_pkg::WINDOW_W;
  localparam int NW  = $clog2(RING_DEPTH + 1);
  localparam int PW  = $clog2(RING_DEPTH);
  localparam int AW  = SW + NW;
  localparam int CMW = (NW > WW) ? NW : WW;
  localparam logic [PW-1:0] STEP_LAST = PW'(RING_DEPTH - 1);

  tma_pkg::state_t      state;
  tma_pkg::state_t      state_next;

  logic [WW-1:0]        window_length;
  logic                 cfg_write;

  logic [PW-1:0]        write_slot;
  logic [PW-1:0]        step;
  logic [NW-1:0]        n_q;
  logic [NW-1:0]        n_eff;
  logic [AW-1:0]        acc;
  logic [SW-1:0]        hi;
  logic [SW-1:0]        lo;
  logic                 zero_q;

  logic                 accept;
  logic                 out_free;
  logic                 load_out;
  logic                 walking;
  logic                 div_start;
  logic                 div_done;
  logic [SW-1:0]        div_q;
  logic [AW-1:0]        drop;
  logic [AW-1:0]        trimmed;
  logic [NW-1:0]        divisor;
  logic [SW-1:0]        head;
  logic                 in_window;

  logic [SW-1:0]              cell_data [RING_DEPTH];
  tma_pkg::cell_ctrl_t        cell_ctrl [RING_DEPTH];

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == tma_pkg::REG_WINDOW_ADDR);

  always_comb begin
    prdata = '0;
    if (paddr == tma_pkg::REG_WINDOW_ADDR) begin
      prdata = tma_pkg::DATA_W'(window_length);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= tma_pkg::WINDOW_RESET;
    end else if (cfg_write) begin
      window_length <= pwdata[WW-1:0];
    end
  end

  // Windows longer than the ring act as the full ring.
  always_comb begin
    if (CMW'(window_length) > CMW'(RING_DEPTH)) begin
      n_eff = NW'(RING_DEPTH);
    end else begin
      n_eff = NW'(window_length);
    end
  end

  // Ring of cells, rotating toward cell 0 during the walk.
  assign accept  = sample_valid && !sample_stall;
  assign walking = (state == tma_pkg::ST_WALK);

  for (genvar k = 0; k < RING_DEPTH; k++) begin : g_cell
    localparam int NEXT = (k + 1) % RING_DEPTH;

    assign cell_ctrl[k].load  = accept && (write_slot == PW'(k));
    assign cell_ctrl[k].shift = walking;

    tma_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cell_ctrl[k]),
      .sample   (sample),
      .shift_in (cell_data[NEXT]),
      .data     (cell_data[k])
    );
  end

  assign head      = cell_data[0];
  assign in_window = (NW'(step) < n_q);

  // Trim and divisor selection.
  always_comb begin
    drop = AW'(hi) + AW'(lo);
    if (n_q > NW'(tma_pkg::TRIM_COUNT)) begin
      trimmed = (acc >= drop) ? (acc - drop) : '0;
      divisor = n_q - NW'(tma_pkg::TRIM_COUNT);
    end else begin
      trimmed = acc;
      divisor = n_q;
    end
  end

  tma_div #(
    .AW (AW),
    .DW (NW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (trimmed),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer.
  assign out_free = !filtered_valid || !filtered_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_stall = 1'b1;
    div_start    = 1'b0;
    load_out     = 1'b0;
    unique case (state)
      tma_pkg::ST_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          state_next = tma_pkg::ST_WALK;
        end
      end
      tma_pkg::ST_WALK: begin
        if (step == STEP_LAST) begin
          state_next = tma_pkg::ST_TRIM;
        end
      end
      tma_pkg::ST_TRIM: begin
        if (n_q == '0) begin
          state_next = tma_pkg::ST_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = tma_pkg::ST_DIV;
        end
      end
      tma_pkg::ST_DIV: begin
        if (div_done) begin
          if (out_free) begin
            load_out   = 1'b1;
            state_next = tma_pkg::ST_IDLE;
          end else begin
            state_next = tma_pkg::ST_DONE;
          end
        end
      end
      tma_pkg::ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = tma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tma_pkg::ST_IDLE;
      end
    endcase
  end

  // Walk datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      acc    <= '0;
      hi     <= sample;
      lo     <= sample;
      n_q    <= n_eff;
      zero_q <= (n_eff == '0);
    end else if (walking && in_window) begin
      acc <= acc + AW'(head);
      if (head > hi) begin
        hi <= head;
      end
      if (head < lo) begin
        lo <= head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (walking) begin
      step <= (step == STEP_LAST) ? '0 : step + PW'(1);
    end
  end

  // The write slot moves only for a nonzero window.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
    end else if (state == tma_pkg::ST_TRIM && n_q != '0) begin
      if (NW'(write_slot) + NW'(1) >= n_q) begin
        write_slot <= '0;
      end else begin
        write_slot <= write_slot + PW'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_valid <= 1'b0;
    end else if (load_out) begin
      filtered_valid <= 1'b1;
    end else if (!filtered_stall) begin
      filtered_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      filtered <= zero_q ? '0 : div_q;
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    write_slot <= STEP_LAST)
    else $error("write slot left the ring");

  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (walking && step == STEP_LAST) |=> (state == tma_pkg::ST_TRIM))
    else $error("walk did not end in the trim step");

  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    accept |=> (walking && step == '0))
    else $error("accepted sample did not start a walk from entry zero");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == tma_pkg::ST_DIV))
    else $error("divider finished outside the divide step");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(filtered_valid) |->
      ($past(state) == tma_pkg::ST_DIV || $past(state) == tma_pkg::ST_DONE))
    else $error("result appeared without a finished computation");

endmodule

`default_nettype wire

// ===== rtl/tma_cell.sv =====
// One ring slot: holds a sample, loads a new one, or takes its neighbor's value on a shift.
`default_nettype none

module tma_cell (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire  tma_pkg::cell_ctrl_t            ctrl,
  input  wire  [tma_pkg::SAMPLE_W-1:0]         sample,
  input  wire  [tma_pkg::SAMPLE_W-1:0]         shift_in,
  output logic [tma_pkg::SAMPLE_W-1:0]         data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else if (ctrl.load) begin
      data <= sample;
    end else if (ctrl.shift) begin
      data <= shift_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tma_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating the quotient to the sample range.
`default_nettype none

module tma_div #(
  parameter int AW = 17,
  parameter int DW = 5
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  start,
  input  wire  [AW-1:0]                        dividend,
  input  wire  [DW-1:0]                        divisor,
  output logic                                 done,
  output logic [tma_pkg::SAMPLE_W-1:0]         quotient
);

  localparam int QW = tma_pkg::SAMPLE_W + 1;
  localparam int CW = $clog2(QW);

  logic [AW-1:0] rem;
  logic [AW-1:0] dsh;
  logic [QW-1:0] quo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          fits;

  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(QW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsh <= AW'(divisor) << tma_pkg::SAMPLE_W;
      quo <= '0;
      cnt <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quo <= {quo[QW-2:0], fits};
      dsh <= dsh >> 1;
      cnt <= cnt + CW'(1);
    end
  end

  // A set top bit means the true quotient does not fit in a sample.
  assign quotient = quo[QW-1] ? '1 : quo[QW-2:0];

endmodule

`default_nettype wire

// ===== tb/tb_trimmed_moving_average_filter.sv =====
// Self-checking testbench of the trimmed moving-average filter with a predictor of its trimmed means.
`timescale 1ns / 100ps

module tb_trimmed_moving_average_filter;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int SAMPLE_MAX  = (1 << tma_pkg::SAMPLE_W) - 1;

  class trimmed_mean_tracker;
    logic [tma_pkg::SAMPLE_W-1:0] ring [tma_pkg::RING_DEPTH_DEF];
    int unsigned                  slot;
    logic [tma_pkg::WINDOW_W-1:0] window;
    logic [tma_pkg::SAMPLE_W-1:0] expected_means [$];
    int unsigned                  errors;

    function new();
      foreach (ring[k]) ring[k] = '0;
      slot   = 0;
      window = tma_pkg::WINDOW_RESET;
      errors = 0;
    endfunction

    function void set_window(input logic [tma_pkg::WINDOW_W-1:0] w);
      window = w;
    endfunction

    function int unsigned pending();
      return expected_means.size();
    endfunction

    function void mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      errors++;
    endfunction

    // Writes the sample into the ring and works out the trimmed mean of the window.
    function void note_sample(input logic [tma_pkg::SAMPLE_W-1:0] smp);
      int unsigned n, acc, hi, lo, drop, mean;
      ring[slot] = smp;
      n = (window > tma_pkg::RING_DEPTH_DEF) ? tma_pkg::RING_DEPTH_DEF : window;
      mean = 0;
      if (n > 0) begin
        acc = 0;
        hi  = smp;
        lo  = smp;
        for (int k = 0; k < n; k++) begin
          acc += ring[k];
          if (ring[k] > hi) hi = ring[k];
          if (ring[k] < lo) lo = ring[k];
        end
        if (n > tma_pkg::TRIM_COUNT) begin
          drop = hi + lo;
          acc  = (acc >= drop) ? acc - drop : 0;
          mean = acc / (n - tma_pkg::TRIM_COUNT);
        end else begin
          mean = acc / n;
        end
        if (mean > SAMPLE_MAX) mean = SAMPLE_MAX;
        slot = (slot >= n - 1) ? 0 : slot + 1;
      end
      expected_means.push_back(tma_pkg::SAMPLE_W'(mean));
    endfunction

    function void check_filtered(input logic [tma_pkg::SAMPLE_W-1:0] got);
      logic [tma_pkg::SAMPLE_W-1:0] want;
      if (expected_means.size() == 0) begin
        $display("%0t: filtered mismatch, expected none actual %0d", $time, got);
        errors++;
        return;
      end
      want = expected_means.pop_front();
      if (got !== want) mismatch("filtered", 32'(want), 32'(got));
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [tma_pkg::ADDR_W-1:0]   paddr = '0;
  logic [tma_pkg::DATA_W-1:0]   pwdata = '0;
  logic [tma_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic [tma_pkg::SAMPLE_W-1:0] sample = '0;
  logic                         sample_valid = 1'b0;
  logic                         sample_stall;
  logic [tma_pkg::SAMPLE_W-1:0] filtered;
  logic                         filtered_valid;
  logic                         filtered_stall = 1'b0;

  trimmed_mean_tracker means;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;
  int unsigned         hold_asks = 0;
  int unsigned         hold_served = 0;
  int unsigned         hold_left = 0;
  int unsigned         cycle_count = 0;

  trimmed_moving_average_filter dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .sample         (sample),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .filtered       (filtered),
    .filtered_valid (filtered_valid),
    .filtered_stall (filtered_stall)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      filtered_stall <= 1'b0;
    end else if (hold_asks != hold_served) begin
      hold_served    <= hold_asks;
      hold_left      <= HOLD_CYCLES;
      filtered_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      filtered_stall <= 1'b1;
    end else begin
      filtered_stall <= (recv_idle_pct != 0) && ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && filtered_valid && !filtered_stall) means.check_filtered(filtered);
  end

  task automatic send_sample(input logic [tma_pkg::SAMPLE_W-1:0] value);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample       <= value;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    means.note_sample(value);
  endtask

  task automatic wait_for_means();
    sample_valid <= 1'b0;
    while (means.pending() != 0) @(posedge clk);
  endtask

  // Lets the block go idle, then writes the window and reads it back.
  task automatic set_window(input logic [tma_pkg::WINDOW_W-1:0] w);
    wait_for_means();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= tma_pkg::REG_WINDOW_ADDR;
    pwdata  <= tma_pkg::DATA_W'(w);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    means.set_window(w);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== tma_pkg::DATA_W'(w)) begin
      means.mismatch("window_length readback", tma_pkg::DATA_W'(w), prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [tma_pkg::SAMPLE_W-1:0] warmup [6];
    logic [tma_pkg::WINDOW_W-1:0] phase_windows [8];
    logic [tma_pkg::WINDOW_W-1:0] w;
    logic [tma_pkg::SAMPLE_W-1:0] v;
    int unsigned                  items;

    warmup        = '{12'd0, 12'd1, 12'd2, 12'hFFF, 12'h555, 12'hAAA};
    phase_windows = '{5'd16, 5'd4, 5'd31, 5'd3, 5'd2, 5'd11, 5'd1, 5'd0};
    means = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (warmup[i]) send_sample(warmup[i]);
    // The next sample lands outside the shortened window, so the trimmed sum goes below zero.
    set_window(5'd3);
    send_sample(12'hFFF);
    set_window(5'd16);
    repeat (3) send_sample(12'hFFF);
    // Again outside the window, now with a quotient above the sample range.
    set_window(5'd3);
    send_sample(12'h000);
    set_window(5'd0);
    send_sample(12'h123);
    send_sample(12'hFFF);
    set_window(5'd1);
    send_sample(12'h800);
    send_sample(12'h7FF);
    set_window(5'd2);
    send_sample(12'hFFF);
    send_sample(12'h001);
    set_window(5'd31);
    send_sample(12'h3C3);
    send_sample(12'hC3C);
    send_sample(12'hFFF);
    set_window(5'd17);
    send_sample(12'h0F0);
    send_sample(12'hF0F);

    for (int ph = 0; ph < 9; ph++) begin
      w = (ph == 8) ? tma_pkg::WINDOW_W'($urandom_range(0, 31)) : phase_windows[ph];
      set_window(w);
      case (ph / 3)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (ph == 6) hold_asks++;
      items = (w == 0) ? 30 : 105;
      repeat (items) begin
        case ($urandom_range(0, 9))
          0: v = '0;
          1: v = '1;
          default: v = tma_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        endcase
        send_sample(v);
      end
    end

    wait_for_means();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (means.errors == 0 && means.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
